// ----- rtl/itoa_pkg.sv -----
// ============================================================================
// itoa_pkg
// Shared widths, codes, control words and the microcode table for the
// integer to radix ASCII converter.
// ============================================================================
`default_nettype none

package itoa_pkg;

    // Word width of the number to convert.
    localparam int WORD_BITS = 32;
    // Width of one digit value (radix is at most 36).
    localparam int DIG_W     = 6;
    // Width of the radix field.
    localparam int BASE_W    = 6;
    // Width of an ASCII character.
    localparam int CHAR_W    = 7;
    // Width of the digit count field.
    localparam int CNTO_W    = 6;
    // Divider bit counter and digit counter widths.
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(WORD_BITS + 1);

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 7'h37;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    // Sequencer steps.
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_INIT,
        STEP_DIV,
        STEP_PUSH,
        STEP_SIGN,
        STEP_DIGIT,
        STEP_SPACE
    } t_step;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_DIV,
        OP_PUSH,
        OP_SIGN,
        OP_DIGIT,
        OP_SPACE
    } t_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_DIV_DONE,
        C_MORE,
        C_SIGN_DONE,
        C_DIGIT_DONE,
        C_EMIT_OK
    } t_cond;

    // One microcode word: on condition true jump to target, otherwise
    // hold the step or advance to the next one.
    typedef struct packed {
        logic  take_in;
        t_op   op;
        t_cond cond;
        t_step target;
        logic  miss_adv;
    } t_uword;

    // Control from sequencer to datapath.
    typedef struct packed {
        logic take_in;
        t_op  op;
    } t_ctrl;

    // Status from datapath to sequencer.
    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic more;
        logic minus;
        logic emit_ok;
        logic last_digit;
    } t_stat;

    function automatic t_uword f_urom(input t_step step);
        t_uword w;
        w = '{take_in: 1'b0, op: OP_NONE, cond: C_ALWAYS,
              target: STEP_IDLE, miss_adv: 1'b0};
        case (step)
            STEP_IDLE: begin
                w = '{take_in: 1'b1, op: OP_LOAD, cond: C_ACCEPT,
                      target: STEP_INIT, miss_adv: 1'b0};
            end
            STEP_INIT: begin
                w = '{take_in: 1'b0, op: OP_CLR, cond: C_ALWAYS,
                      target: STEP_DIV, miss_adv: 1'b0};
            end
            STEP_DIV: begin
                w = '{take_in: 1'b0, op: OP_DIV, cond: C_DIV_DONE,
                      target: STEP_PUSH, miss_adv: 1'b0};
            end
            STEP_PUSH: begin
                w = '{take_in: 1'b0, op: OP_PUSH, cond: C_MORE,
                      target: STEP_INIT, miss_adv: 1'b1};
            end
            STEP_SIGN: begin
                w = '{take_in: 1'b0, op: OP_SIGN, cond: C_SIGN_DONE,
                      target: STEP_DIGIT, miss_adv: 1'b0};
            end
            STEP_DIGIT: begin
                w = '{take_in: 1'b0, op: OP_DIGIT, cond: C_DIGIT_DONE,
                      target: STEP_SPACE, miss_adv: 1'b0};
            end
            STEP_SPACE: begin
                w = '{take_in: 1'b0, op: OP_SPACE, cond: C_EMIT_OK,
                      target: STEP_IDLE, miss_adv: 1'b0};
            end
            default: begin
                w = '{take_in: 1'b0, op: OP_NONE, cond: C_ALWAYS,
                      target: STEP_IDLE, miss_adv: 1'b0};
            end
        endcase
        return w;
    endfunction

    // Clamp the radix into 2..36.
    function automatic logic [BASE_W-1:0] f_clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end
        return r;
    endfunction

    // Digit value to ASCII character.
    function automatic logic [CHAR_W-1:0] f_dig_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIG_W'(10)) begin
            c = CH_ZERO + CHAR_W'(d);
        end else begin
            c = CH_SEVEN + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/itoa_if.sv -----
// ============================================================================
// itoa_if
// Request channels of the converter: number in, characters out.
// ============================================================================
`default_nettype none

interface itoa_in_if;
    import itoa_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] value;
    logic        [BASE_W-1:0]    base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface itoa_out_if;
    import itoa_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic [CNTO_W-1:0] digit_count;
    logic              last;

    modport source (output valid, output ascii_char, output digit_count,
                    output last, input ready);
    modport sink   (input valid, input ascii_char, input digit_count,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/itoa_seq.sv -----
// ============================================================================
// itoa_seq
// Step counter and microcode table; evaluates jump conditions.
// ============================================================================
`default_nettype none

module itoa_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire itoa_pkg::t_stat i_stat,
    output itoa_pkg::t_ctrl      o_ctrl
);
    import itoa_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword w_uw;
    logic   w_hit;

    assign w_uw = f_urom(r_pc);

    always_comb begin
        case (w_uw.cond)
            C_ALWAYS:     w_hit = 1'b1;
            C_ACCEPT:     w_hit = i_stat.in_valid;
            C_DIV_DONE:   w_hit = i_stat.div_done;
            C_MORE:       w_hit = i_stat.more;
            C_SIGN_DONE:  w_hit = !i_stat.minus || i_stat.emit_ok;
            C_DIGIT_DONE: w_hit = i_stat.emit_ok && i_stat.last_digit;
            C_EMIT_OK:    w_hit = i_stat.emit_ok;
            default:      w_hit = 1'b1;
        endcase
    end

    // Next step: jump on hit, else advance or hold.
    always_comb begin
        if (w_hit) begin
            n_pc = w_uw.target;
        end else if (w_uw.miss_adv) begin
            n_pc = t_step'(r_pc + 3'd1);
        end else begin
            n_pc = r_pc;
        end
    end

    // Control word fields to the datapath.
    always_comb begin
        o_ctrl.take_in = w_uw.take_in;
        o_ctrl.op      = w_uw.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/itoa_dp.sv -----
// ============================================================================
// itoa_dp
// Datapath: bit-serial restoring divider, digit stack, output register.
// ============================================================================
`default_nettype none

module itoa_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire itoa_pkg::t_ctrl i_ctrl,
    output itoa_pkg::t_stat      o_stat,
    itoa_in_if.sink              i_in,
    itoa_out_if.source           o_out
);
    import itoa_pkg::*;

    logic [WORD_BITS-1:0] r_val;
    logic [BASE_W-1:0]    r_radix;
    logic [DIG_W-1:0]     r_rem;
    logic [BIT_W-1:0]     r_bit;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_left;
    logic                 r_minus;
    logic [DIG_W-1:0]     r_stk [WORD_BITS];

    logic                 r_ov;
    logic [CHAR_W-1:0]    r_char;
    logic [CNTO_W-1:0]    r_cnt;
    logic                 r_last;

    logic                 w_accept;
    logic [WORD_BITS-1:0] w_v;
    logic [BASE_W-1:0]    w_radix;
    logic                 w_minus;
    logic [DIG_W:0]       w_trial;
    logic                 w_ge;
    logic                 w_emit_ok;
    logic                 w_load_out;
    logic [CHAR_W-1:0]    w_char;
    logic                 w_last;

    assign i_in.ready = i_ctrl.take_in;
    assign w_accept   = i_ctrl.take_in && i_in.valid;
    assign w_v        = WORD_BITS'(i_in.value);
    assign w_radix    = f_clamp_base(i_in.base);
    assign w_minus    = w_v[WORD_BITS-1] && (w_radix == BASE_DEC);

    // One quotient bit per cycle.
    assign w_trial = {r_rem, r_val[WORD_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_radix};

    assign w_emit_ok = !r_ov || o_out.ready;

    always_comb begin
        w_load_out = 1'b0;
        w_char     = CH_SPACE;
        w_last     = 1'b0;
        case (i_ctrl.op)
            OP_SIGN: begin
                w_load_out = w_emit_ok && r_minus;
                w_char     = CH_MINUS;
            end
            OP_DIGIT: begin
                w_load_out = w_emit_ok;
                w_char     = f_dig_char(r_stk[0]);
            end
            OP_SPACE: begin
                w_load_out = w_emit_ok;
                w_last     = 1'b1;
            end
            default: begin
                w_load_out = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_stat.in_valid   = i_in.valid;
        o_stat.div_done   = r_bit == BIT_W'(WORD_BITS - 1);
        o_stat.more       = (r_val != '0) && (r_n < CNT_W'(WORD_BITS - 1));
        o_stat.minus      = r_minus;
        o_stat.emit_ok    = w_emit_ok;
        o_stat.last_digit = r_left == CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD: begin
                if (w_accept) begin
                    r_val   <= w_minus ? (~w_v + WORD_BITS'(1)) : w_v;
                    r_radix <= w_radix;
                    r_minus <= w_minus;
                    r_n     <= '0;
                    r_left  <= '0;
                end
            end
            OP_CLR: begin
                r_rem <= '0;
                r_bit <= '0;
            end
            OP_DIV: begin
                r_rem <= w_ge ? DIG_W'(w_trial - {1'b0, r_radix}) : w_trial[DIG_W-1:0];
                r_val <= {r_val[WORD_BITS-2:0], w_ge};
                r_bit <= r_bit + BIT_W'(1);
            end
            OP_PUSH: begin
                r_stk[0] <= r_rem;
                for (int i = 1; i < WORD_BITS; i++) begin
                    r_stk[i] <= r_stk[i-1];
                end
                r_n    <= r_n + CNT_W'(1);
                r_left <= r_left + CNT_W'(1);
            end
            OP_DIGIT: begin
                if (w_emit_ok) begin
                    for (int i = 0; i < WORD_BITS - 1; i++) begin
                        r_stk[i] <= r_stk[i+1];
                    end
                    r_left <= r_left - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register; holds until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_char <= w_char;
            r_cnt  <= CNTO_W'(r_n);
            r_last <= w_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.ascii_char  = r_char;
    assign o_out.digit_count = r_cnt;
    assign o_out.last        = r_last;

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_ascii.sv -----
// Steps: per digit the divider clears, shifts the quotient in bit by bit
//   and pushes the remainder; then the sign step, each digit character and
//   the closing space follow. The single one-bit-per-cycle divider serves
//   every digit in turn, and a stalled sink holds the emit steps.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and
//   empties the output register; in idle the block is ready for a request.
// ============================================================================
// integer_to_radix_ascii
// Converts a signed word to ASCII digits in radix 2..36, most significant
// digit first, with an optional '-' (decimal only) and a closing space.
// ============================================================================
`default_nettype none

module integer_to_radix_ascii (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);
    import itoa_pkg::*;

    // Control word from the microcode table and status back from the datapath.
    t_ctrl w_ctrl;
    t_stat w_stat;

    // Sequencer program, one step a cycle unless it holds:
    //   IDLE  take a request, clamp radix, strip sign for negative decimal
    //   INIT  clear remainder and bit counter
    //   DIV   shift one quotient bit per cycle, in place over the value
    //   PUSH  push remainder on the digit stack; loop while quotient nonzero
    //   SIGN  emit '-' when needed
    //   DIGIT pop digits, most significant first
    //   SPACE emit the closing space flagged last, back to IDLE
    itoa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // Divider, digit stack and output register; the output register lets the
    // last character wait for the sink while the next request is taken.
    itoa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/itoa_chk.sv -----
// ============================================================================
// itoa_chk
// Port-level checks of the converter, bound to the top level.
// ============================================================================
`default_nettype none

module itoa_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [itoa_pkg::CHAR_W-1:0]  i_ascii_char,
    input wire logic [itoa_pkg::CNTO_W-1:0]  i_digit_count,
    input wire logic                         i_last
);
    import itoa_pkg::*;

    // A run is open from request accept until its last character is taken.
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_in_valid && i_in_ready) begin
            r_busy <= 1'b1;
        end else if (i_out_valid && i_out_ready && i_last) begin
            r_busy <= 1'b0;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_ascii_char)
            && $stable(i_digit_count) && $stable(i_last))
        else $error("output changed while stalled");

    a_last_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_ascii_char == CH_SPACE)))
        else $error("last flag does not match closing space");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_digit_count >= CNTO_W'(1))
            && (i_digit_count <= CNTO_W'(WORD_BITS)))
        else $error("digit count out of range");

    a_one_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !r_busy || (i_out_valid && i_last))
        else $error("request taken while a run is still open");

endmodule

bind integer_to_radix_ascii itoa_chk u_itoa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_ascii_char  (o_out.ascii_char),
    .i_digit_count (o_out.digit_count),
    .i_last        (o_out.last)
);

`default_nettype wire

// ----- sim/integer_to_radix_ascii_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// integer_to_radix_ascii_test
// Self-checking bench for the integer to radix ASCII converter. Each number
// is spelled out by an independent predictor when its request is accepted,
// and every character that leaves the block is compared against the oldest
// prediction, with random idling on both request channels.
// ============================================================================

import itoa_pkg::*;

class itoa_scoreboard;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CNTO_W-1:0] cnt;
        logic              last;
    } t_char_exp;

    t_char_exp expected_chars[$];
    int        n_errors;
    int        n_numbers;
    int        n_chars;
    int        n_signed;
    int        n_clamped;

    function new();
        n_errors  = 0;
        n_numbers = 0;
        n_chars   = 0;
        n_signed  = 0;
        n_clamped = 0;
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

    // Spell one accepted number into the expected character stream.
    function void spell_number(input logic [WORD_BITS-1:0] value,
                               input logic [BASE_W-1:0] base);
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] radix;
        logic [WORD_BITS-1:0] rem;
        logic [CHAR_W-1:0]    digits[$];
        logic [CNTO_W-1:0]    n;
        bit                   neg;

        radix = WORD_BITS'(base);
        if (base < BASE_MIN) begin
            radix = WORD_BITS'(BASE_MIN);
            n_clamped++;
        end else if (base > BASE_MAX) begin
            radix = WORD_BITS'(BASE_MAX);
            n_clamped++;
        end

        // Only decimal shows a sign; other radixes print the raw pattern.
        neg = value[WORD_BITS-1] && (radix == WORD_BITS'(BASE_DEC));
        mag = neg ? (~value + 1'b1) : value;
        if (neg) begin
            n_signed++;
        end

        do begin
            rem = mag % radix;
            if (rem < 10) begin
                digits.push_front(CHAR_W'(rem) + CH_ZERO);
            end else begin
                digits.push_front(CHAR_W'(rem) + CH_SEVEN);
            end
            mag = mag / radix;
        end while (mag != 0 && digits.size() < WORD_BITS);

        n = CNTO_W'(digits.size());
        if (neg) begin
            expected_chars.push_back('{ch: CH_MINUS, cnt: n, last: 1'b0});
        end
        foreach (digits[i]) begin
            expected_chars.push_back('{ch: digits[i], cnt: n, last: 1'b0});
        end
        expected_chars.push_back('{ch: CH_SPACE, cnt: n, last: 1'b1});
        n_numbers++;
    endfunction

    // Compare one delivered character with the oldest expectation.
    function void check_char(input logic [CHAR_W-1:0] ch,
                             input logic [CNTO_W-1:0] cnt,
                             input logic last);
        t_char_exp e;
        bit        bad;

        n_chars++;
        if (expected_chars.size() == 0) begin
            n_errors++;
            $display("%0t: character 0x%02h with no request pending", $time, ch);
            return;
        end
        e   = expected_chars.pop_front();
        bad = 1'b0;
        if (ch !== e.ch) begin
            $display("%0t: ascii_char expected 0x%02h actual 0x%02h",
                     $time, e.ch, ch);
            bad = 1'b1;
        end
        if (cnt !== e.cnt) begin
            $display("%0t: digit_count expected %0d actual %0d",
                     $time, e.cnt, cnt);
            bad = 1'b1;
        end
        if (last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, last);
            bad = 1'b1;
        end
        if (bad) begin
            n_errors++;
        end
    endfunction

endclass

module integer_to_radix_ascii_test;

    localparam int HOLD_CYCLES  = 600;               // long sink stall
    localparam int DRAIN_CYCLES = 4 * (WORD_BITS + 2);
    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_ITEMS = 72;

    logic i_clk;
    logic i_rst_n;

    itoa_in_if  in_ch();
    itoa_out_if out_ch();

    itoa_scoreboard sb = new();

    // Shared knobs between the stimulus and the sink process.
    bit no_idle;
    bit sink_hold_req;

    integer_to_radix_ascii DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running 4 ns clock.
    initial begin
        i_clk = 1'b0;
    end
    always #2 i_clk = ~i_clk;

    // Drive every block input to a known value from time zero.
    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        in_ch.base    = '0;
        out_ch.ready  = 1'b0;
        no_idle       = 1'b0;
        sink_hold_req = 1'b0;
    end

    // Offer one request and hold it until the block takes it. Inputs move
    // only at the falling edge; acceptance is judged at the rising edge.
    task automatic send_request(input logic [WORD_BITS-1:0] value,
                                input logic [BASE_W-1:0] base);
        @(negedge i_clk);
        // Idle the channel for a random number of cycles first.
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.base  <= base;
        // Wait for the handshake, then log the request for prediction.
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        sb.spell_number(value, base);
    endtask

    // Drop valid once the last request has gone.
    task automatic stop_requests();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Hold the sender until every predicted character has come out.
    task automatic wait_results_drained();
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Pick a random number with a mix of shapes: full words, small
    // magnitudes of either sign, and values near the word extremes.
    function automatic logic [WORD_BITS-1:0] pick_value();
        logic [WORD_BITS-1:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom;
            2:    v = WORD_BITS'($urandom_range(0, 999));
            3:    v = -WORD_BITS'($urandom_range(1, 999));
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    v = {1'b1, {(WORD_BITS-1){1'b0}}} + $urandom_range(0, 3);
                end else begin
                    v = {1'b0, {(WORD_BITS-1){1'b1}}} - $urandom_range(0, 3);
                end
            end
        endcase
        return v;
    endfunction

    // Mostly legal radixes with decimal favored, plus a share of raw codes
    // that exercise clamping at both ends.
    function automatic logic [BASE_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return BASE_DEC;
        end else if (r < 88) begin
            return BASE_W'($urandom_range(2, 36));
        end
        return BASE_W'($urandom_range(0, 63));
    endfunction

    // Sink side: stall at random, except during the steady stretch, and
    // honor a request for one long hold-off counted right here.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    out_ch.ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check every character the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_char(out_ch.ascii_char, out_ch.digit_count, out_ch.last);
        end
    end

    // Main sequence.
    initial begin
        // Hold reset at first, release it on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: zero, all-ones, the word extremes, digit letters,
        // decimal sign handling and both ends of radix clamping.
        send_request(32'd0,          BASE_DEC);
        send_request(32'd0,          BASE_W'(2));
        send_request(32'hFFFF_FFFF,  BASE_DEC);
        send_request(32'hFFFF_FFFF,  BASE_W'(2));
        send_request(32'hFFFF_FFFF,  BASE_W'(16));
        send_request(32'h8000_0000,  BASE_DEC);
        send_request(32'h8000_0000,  BASE_W'(2));
        send_request(32'h7FFF_FFFF,  BASE_DEC);
        send_request(32'h7FFF_FFFF,  BASE_W'(36));
        send_request(32'h7FFF_FFFF,  BASE_W'(2));
        send_request(32'd35,         BASE_W'(36));
        send_request(32'd10,         BASE_W'(11));
        send_request(32'd12345,      BASE_DEC);
        send_request(-32'sd12345,    BASE_DEC);
        send_request(32'hDEAD_BEEF,  BASE_W'(16));
        send_request(32'd255,        BASE_W'(8));
        send_request(32'd80,         BASE_W'(3));
        send_request(32'd5,          BASE_W'(0));
        send_request(32'd5,          BASE_W'(1));
        send_request(32'd1295,       BASE_W'(37));
        send_request(32'hFFFF_FFFF,  BASE_W'(63));
        send_request(-32'sd7,        BASE_W'(9));

        // Let everything drain before the random part.
        stop_requests();
        wait_results_drained();

        // Long sink stall while requests keep coming, so the block backs up
        // and refuses new numbers for a while.
        sink_hold_req = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_request(WORD_BITS'($urandom_range(0, 99999)), pick_base());
        end

        // Random part, with one stretch where neither side idles.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 40 && i < 65);
            send_request(pick_value(), pick_base());
        end
        no_idle = 1'b0;
        stop_requests();

        // Drain, then give the block time to emit anything stray.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Converted %0d numbers (%0d signed decimal, %0d clamped radix)",
                 sb.n_numbers, sb.n_signed, sb.n_clamped);
        $display("Checked %0d characters, %0d mismatching", sb.n_chars, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #(3_000_000);
        $display("Timeout with %0d characters still expected", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- integer_to_radix_ascii.f -----
rtl/itoa_pkg.sv
rtl/itoa_if.sv
rtl/itoa_seq.sv
rtl/itoa_dp.sv
rtl/integer_to_radix_ascii.sv
rtl/itoa_chk.sv
sim/integer_to_radix_ascii_test.sv
